// ----- hdl/sbk_pkg.sv -----
// Package for the two-key sort and order hash block.
// Holds the record types, the queue depth, the back-end states and the sort compare.
// No dependencies.
package sbk_pkg;

  localparam int unsigned QueueDepth = 4;

  // One request as it travels from the front queue to the back end.
  typedef struct packed {
    logic [31:0] record_id;
    logic [31:0] damage;
    logic [31:0] tie_key;
    logic        last_record;
  } sbk_rec_t;

  // One stored entry of the sorted table.
  typedef struct packed {
    logic [31:0] record_id;
    logic [31:0] damage;
    logic [31:0] tie_key;
  } sbk_ent_t;

  // Status of the back end, seen by the top level.
  typedef struct packed {
    logic idle;
    logic empty;
    logic full;
  } sbk_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_PLACE,
    ST_HASH_RD,
    ST_HASH_ACC,
    ST_EMIT
  } sbk_state_t;

  // True if (d1,k1) sorts strictly before (d2,k2): damage descending, key ascending.
  function automatic logic goes_before(logic [31:0] d1, logic [31:0] k1,
                                       logic [31:0] d2, logic [31:0] k2);
    logic ahead;
    ahead = 1'b0;
    if (d1 != d2) begin
      ahead = ($signed(d1) > $signed(d2));
    end else begin
      ahead = (k1 < k2);
    end
    return ahead;
  endfunction

endpackage

// ----- hdl/sbk_front.sv -----
// Front end of the sort block: accepts requests into a short queue.
// Depends on sbk_pkg for the request type and the queue depth.
module sbk_front
  import sbk_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  sbk_rec_t in_rec,
  output logic     q_valid,
  input  logic     q_ready,
  output sbk_rec_t q_rec
);

  localparam int unsigned QAW = $clog2(QueueDepth);
  localparam int unsigned QCW = $clog2(QueueDepth + 1);

  sbk_rec_t        slots [QueueDepth];
  logic [QAW-1:0]  wr_ptr;
  logic [QAW-1:0]  rd_ptr;
  logic [QCW-1:0]  level;
  logic            push;
  logic            pop;

  assign in_ready = (level != QCW'(QueueDepth));
  assign q_valid  = (level != '0);
  assign q_rec    = slots[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        level <= level + 1'b1;
      end else if (pop && !push) begin
        level <= level - 1'b1;
      end
    end
  end

endmodule

// ----- hdl/sbk_back.sv -----
// Back end of the sort block: insertion into the sorted table, hash walk, result register.
// Depends on sbk_pkg for types, states and the sort compare.
module sbk_back
  import sbk_pkg::*;
#(
  parameter int unsigned MAX_RECORDS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        q_ready,
  input  sbk_rec_t    q_rec,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] order_hash,
  output logic        overflowed,
  output sbk_status_t status
);

  localparam int unsigned CW = $clog2(MAX_RECORDS + 1);
  localparam int unsigned AW = $clog2(MAX_RECORDS);

  sbk_ent_t       mem [MAX_RECORDS];
  sbk_ent_t       rd_data;
  logic [AW-1:0]  rd_addr;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  sbk_ent_t       mem_wdata;

  sbk_state_t     state;
  sbk_state_t     state_next;
  logic [CW-1:0]  count;
  logic           ovf;
  logic [CW-1:0]  pos;
  logic [CW-1:0]  idx;
  sbk_rec_t       cur;
  logic [63:0]    acc;

  logic           take;
  logic           full;
  logic           ahead;
  logic           emit_go;
  logic [63:0]    id_ext;

  assign take    = q_valid && q_ready;
  assign full    = (count == CW'(MAX_RECORDS));
  assign ahead   = goes_before(cur.damage, cur.tie_key, rd_data.damage, rd_data.tie_key);
  assign emit_go = !out_valid || out_ready;
  assign id_ext  = {{32{rd_data.record_id[31]}}, rd_data.record_id};

  assign status.idle  = (state == ST_IDLE);
  assign status.empty = (count == '0);
  assign status.full  = full;

  // Table memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (take) begin
          if (full || count == '0) begin
            state_next = q_rec.last_record ? ST_HASH_RD : ST_IDLE;
          end else begin
            state_next = ST_CMP;
          end
        end
      end
      ST_CMP: begin
        if (ahead) begin
          state_next = (pos == CW'(1)) ? ST_PLACE : ST_CMP;
        end else begin
          state_next = cur.last_record ? ST_HASH_RD : ST_IDLE;
        end
      end
      ST_PLACE:    state_next = cur.last_record ? ST_HASH_RD : ST_IDLE;
      ST_HASH_RD:  state_next = ST_HASH_ACC;
      ST_HASH_ACC: state_next = (idx + 1'b1 == count) ? ST_EMIT : ST_HASH_ACC;
      ST_EMIT:     state_next = emit_go ? ST_IDLE : ST_EMIT;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Outputs: queue pop and memory port controls.
  always_comb begin
    q_ready   = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = pos[AW-1:0];
    mem_wdata = '{record_id: cur.record_id, damage: cur.damage, tie_key: cur.tie_key};
    rd_addr   = '0;
    unique case (state)
      ST_IDLE: begin
        q_ready = 1'b1;
        rd_addr = AW'(count - 1'b1);
        if (take && !full && count == '0) begin
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wdata = '{record_id: q_rec.record_id, damage: q_rec.damage,
                        tie_key: q_rec.tie_key};
        end
      end
      ST_CMP: begin
        mem_we = 1'b1;
        if (ahead) begin
          mem_wdata = rd_data;
          rd_addr   = AW'(pos - CW'(2));
        end
      end
      ST_PLACE:    mem_we  = 1'b1;
      ST_HASH_RD:  rd_addr = '0;
      ST_HASH_ACC: rd_addr = AW'(idx + 1'b1);
      ST_EMIT:     rd_addr = '0;
      default:     rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_EMIT && emit_go) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (take) begin
            if (full) begin
              ovf <= 1'b1;
            end else if (count == '0) begin
              count <= CW'(1);
            end
          end
        end
        ST_CMP: begin
          if (!ahead) begin
            count <= count + 1'b1;
          end
        end
        ST_PLACE: count <= count + 1'b1;
        ST_EMIT: begin
          if (emit_go) begin
            count <= '0;
            ovf   <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (take) begin
          cur <= q_rec;
          pos <= count;
        end
      end
      ST_CMP: begin
        if (ahead) begin
          pos <= pos - 1'b1;
        end
      end
      ST_HASH_RD: begin
        acc <= '0;
        idx <= '0;
      end
      ST_HASH_ACC: begin
        acc <= (acc << 5) - acc + id_ext;
        idx <= idx + 1'b1;
      end
      ST_EMIT: begin
        if (emit_go) begin
          order_hash <= acc;
          overflowed <= ovf;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- hdl/sort_by_key_then_order_hash.sv -----
// A record passes through the front queue and is then inserted by a walk down the table from
// its tail that moves each stored record it goes before up one place, or is written directly
// if the table is empty, or dropped if it is full; a last record then starts the hash walk over
// the stored records. The back end takes a new record only once the previous one is done.
// Reset (rst, synchronous, active high) empties the queue and the batch; the table is not
// cleared, since only entries below the record count are ever read.
module sort_by_key_then_order_hash
  import sbk_pkg::*;
#(
  parameter int unsigned MAX_RECORDS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] record_id,
  input  logic signed [31:0] damage,
  input  logic        [31:0] tie_key,
  input  logic               last_record,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [63:0] order_hash,
  output logic               overflowed
);

  // The front end only queues requests, so the input side keeps taking records, until the
  // queue is full, while the back end is busy shifting the table or walking the hash.
  sbk_rec_t    in_rec;
  sbk_rec_t    q_rec;
  logic        q_valid;
  logic        q_ready;
  logic [63:0] hash_raw;
  sbk_status_t status;

  assign in_rec = '{record_id: record_id, damage: damage, tie_key: tie_key,
                    last_record: last_record};

  sbk_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_rec   (in_rec),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_rec    (q_rec)
  );

  // The back end holds the sorted table. Each new record is compared against the
  // table from its tail downwards; every entry that it goes before is moved up one
  // place. The hash walk then reads the table in order, folding acc*31 + id with a
  // shift and subtract, and the result waits in an output register.
  sbk_back #(
    .MAX_RECORDS (MAX_RECORDS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_rec      (q_rec),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .order_hash (hash_raw),
    .overflowed (overflowed),
    .status     (status)
  );

  assign order_hash = $signed(hash_raw);

`ifndef SYNTHESIS
  // A new result is only ever loaded together with the clearing of the batch.
  a_batch_clears: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> status.empty)
    else $error("result loaded without clearing the batch");

  // The back end takes a request from the queue only between records.
  a_take_when_idle: assert property (@(posedge clk) disable iff (rst)
    (q_valid && q_ready) |-> status.idle)
    else $error("queue popped while the back end was busy");

  // A full table stays full until the batch ends, and then it is empty.
  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    status.full |=> (status.full || status.empty))
    else $error("full table lost records outside a batch end");
`endif

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for sort_by_key_then_order_hash: sorted batches and their order hashes.
// Depends on the block's RTL only; expected hashes come from a record table kept in the bench.
`timescale 1ns / 1ps

module tb_top;

  // Table size of the block under test, and the multiplier of the polynomial hash.
  localparam int unsigned CAPACITY      = 64;
  localparam logic [63:0] HASH_MULT     = 64'd31;
  // Length of the long output hold-off, in clock cycles.
  localparam int unsigned HOLD_CYCLES   = 400;
  // Quiet cycles after the last result, enough for a full insert and hash walk.
  localparam int unsigned SETTLE_CYCLES = 200;
  // Fixed time limit for the whole run, in ns, with the clock at a 2 ns period.
  localparam int unsigned TIMEOUT_NS    = 2_000_000;

  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               in_valid    = 1'b0;
  logic               in_ready;
  logic signed [31:0] record_id   = '0;
  logic signed [31:0] damage      = '0;
  logic        [31:0] tie_key     = '0;
  logic               last_record = 1'b0;
  logic               out_valid;
  logic               out_ready   = 1'b0;
  logic signed [63:0] order_hash;
  logic               overflowed;

  // One expected result: the hash of a closed batch and whether records were lost.
  typedef struct {
    logic [63:0] hash;
    logic        dropped;
  } hash_result_t;

  hash_result_t       pending_hashes[$];
  hash_result_t       oldest;

  // The bench's own copy of the sorted batch, kept in the same order as the block's table.
  logic signed [31:0] batch_id[CAPACITY];
  logic signed [31:0] batch_dmg[CAPACITY];
  logic        [31:0] batch_key[CAPACITY];
  int unsigned        batch_count   = 0;
  logic               batch_dropped = 1'b0;

  int unsigned        error_count       = 0;
  int unsigned        records_sent      = 0;
  int unsigned        sender_idle_pct   = 0;
  int unsigned        receiver_idle_pct = 0;
  int unsigned        stall_left        = 0;
  bit                 hold_request      = 1'b0;
  logic        [31:0] last_key          = '0;

  initial begin
    forever #1 clk = ~clk;
  end

  sort_by_key_then_order_hash #(
    .MAX_RECORDS(CAPACITY)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .record_id  (record_id),
    .damage     (damage),
    .tie_key    (tie_key),
    .last_record(last_record),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .order_hash (order_hash),
    .overflowed (overflowed)
  );

  // True when a new record ranks strictly ahead of a stored one: higher damage first, and on
  // equal damage the smaller tie key first. Equal records do not outrank each other, so a
  // newcomer settles behind its equals and arrival order is kept.
  function automatic bit outranks(logic signed [31:0] dmg_new, logic [31:0] key_new,
                                  logic signed [31:0] dmg_old, logic [31:0] key_old);
    if (dmg_new != dmg_old) begin
      return dmg_new > dmg_old;
    end
    return key_new < key_old;
  endfunction

  // Files one accepted request into the bench's batch and, when it closes the batch, works out
  // the order hash over the ids in sorted order and queues it as the next expected result.
  function void insert_and_hash(logic signed [31:0] id, logic signed [31:0] dmg,
                                logic [31:0] key, logic last);
    int unsigned        pos;
    logic        [63:0] acc;
    logic signed [63:0] widened;
    if (batch_count >= CAPACITY) begin
      // The table is full: the request is lost, but a last marker still closes the batch.
      batch_dropped = 1'b1;
    end else begin
      pos = batch_count;
      while (pos > 0 && outranks(dmg, key, batch_dmg[pos-1], batch_key[pos-1])) begin
        batch_id[pos]  = batch_id[pos-1];
        batch_dmg[pos] = batch_dmg[pos-1];
        batch_key[pos] = batch_key[pos-1];
        pos--;
      end
      batch_id[pos]  = id;
      batch_dmg[pos] = dmg;
      batch_key[pos] = key;
      batch_count++;
    end
    if (last) begin
      acc = '0;
      for (int unsigned i = 0; i < batch_count; i++) begin
        // Ids are sign-extended to 64 bits; the sum wraps modulo 2^64.
        widened = batch_id[i];
        acc = acc * HASH_MULT + widened;
      end
      pending_hashes.push_back('{hash: acc, dropped: batch_dropped});
      batch_count   = 0;
      batch_dropped = 1'b0;
    end
  endfunction

  // Result checker. Values are sampled at the rising edge, before this edge's updates land, so
  // they are the ones the handshake saw.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_hashes.size() == 0) begin
        $display("%0t: result with nothing expected: order_hash %h overflowed %b",
                 $time, order_hash, overflowed);
        error_count++;
      end else begin
        oldest = pending_hashes.pop_front();
        if (order_hash !== oldest.hash) begin
          $display("%0t: order_hash expected %h actual %h", $time, oldest.hash, order_hash);
          error_count++;
        end
        if (overflowed !== oldest.dropped) begin
          $display("%0t: overflowed expected %b actual %b", $time, oldest.dropped, overflowed);
          error_count++;
        end
      end
    end
  end

  // Receiver. It stalls at random at the current rate, and on a hold request it keeps ready
  // low for a long stretch, counting the cycles itself.
  always @(posedge clk) begin
    if (hold_request) begin
      stall_left   = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end
  end

  // Offers one request, with a random idle gap in front of it at the current sender rate, and
  // waits for it to be taken. Called at a rising edge; returns at the edge of acceptance with
  // valid still high, so a request that follows straight on keeps valid up without a dip.
  task automatic send_record(input logic signed [31:0] id, input logic signed [31:0] dmg,
                             input logic [31:0] key, input logic last);
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < sender_idle_pct);
    end
    in_valid    <= 1'b1;
    record_id   <= id;
    damage      <= dmg;
    tie_key     <= key;
    last_record <= last;
    do @(posedge clk); while (in_ready !== 1'b1);
    insert_and_hash(id, dmg, key, last);
    records_sent++;
  endtask

  // Drops valid and pauses the sender until every expected result has come out.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_hashes.size() != 0);
  endtask

  // A record with random content. Damage is often drawn from a few values, the extremes among
  // them, so that ties on damage are common; the tie key now and then repeats the last one or
  // sits at an extreme, so that fully equal records occur too.
  task automatic send_random_record(input logic last);
    logic signed [31:0] dmg;
    logic        [31:0] key;
    case ($urandom_range(0, 7))
      0:       dmg = 32'h8000_0000;
      1:       dmg = 32'h7fff_ffff;
      2, 3, 4: dmg = $urandom_range(0, 4) - 2;
      default: dmg = $urandom;
    endcase
    case ($urandom_range(0, 15))
      0:       key = last_key;
      1:       key = '0;
      2:       key = '1;
      default: key = $urandom;
    endcase
    last_key = key;
    send_record($urandom, dmg, key, last);
  endtask

  task automatic send_random_batch(input int unsigned size);
    for (int unsigned n = 1; n <= size; n++) begin
      send_random_record(n == size);
    end
  endtask

  // Mostly short batches, so that results are plentiful; now and then a long one, and rarely
  // one that fills the table or runs past it.
  function automatic int unsigned pick_batch_size();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) begin
      return $urandom_range(1, 8);
    end else if (roll < 95) begin
      return $urandom_range(9, CAPACITY - 1);
    end else if (roll < 98) begin
      return CAPACITY;
    end
    return $urandom_range(CAPACITY + 1, CAPACITY + 4);
  endfunction

  // Batches of a single record with the fields at or near their extremes, or around zero.
  task automatic test_lone_extremes();
    send_record(32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 1'b1);
    send_record(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 1'b1);
    send_record(-1, 0, 32'h0000_0001, 1'b1);
    send_record(0, -1, 32'hffff_fffe, 1'b1);
  endtask

  // Hand-built batches that exercise the ordering rules.
  task automatic test_sort_order();
    // Equal damage arriving in falling key order, a fully equal pair that must stay in arrival
    // order, and damage at both extremes and on either side of zero.
    send_record(11, 5, 10, 1'b0);
    send_record(12, 5, 3, 1'b0);
    send_record(13, 5, 3, 1'b0);
    send_record(14, 32'h7fff_ffff, 7, 1'b0);
    send_record(15, 32'h8000_0000, 0, 1'b0);
    send_record(16, -1, 2, 1'b0);
    send_record(17, 0, 2, 1'b1);
    // Records that arrive already in order need no shifting.
    send_record(21, 100, 1, 1'b0);
    send_record(22, 100, 2, 1'b1);
    // Ids near the sign boundary, so the sign extension shows in the hash.
    send_record(32'h8000_0001, -7, 5, 1'b0);
    send_record(32'h7fff_ffff, -7, 5, 1'b1);
  endtask

  // A batch that exactly fills the table, one whose closing request is lost to a full table
  // but still produces a result, and one that overruns by a few records.
  task automatic test_capacity();
    send_random_batch(CAPACITY);
    send_random_batch(CAPACITY + 1);
    send_random_batch(CAPACITY + 3);
    wait_for_results();
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering. The first
  // result cannot leave, so the second stalls the back end in its output stage; the records
  // of the third batch then fill the front queue and the input stalls.
  task automatic test_output_hold_off();
    hold_request = 1'b1;
    send_random_batch(2);
    send_random_batch(12);
    send_random_batch(8);
    wait_for_results();
  endtask

  task automatic test_random_batches(input int unsigned budget);
    int unsigned start;
    start = records_sent;
    while (records_sent - start < budget) begin
      send_random_batch(pick_batch_size());
    end
    wait_for_results();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Sender idles often, receiver very often.
    sender_idle_pct   = 38;
    receiver_idle_pct = 81;
    test_lone_extremes();
    test_sort_order();
    test_capacity();
    test_random_batches(200);

    // The other way round.
    sender_idle_pct   = 81;
    receiver_idle_pct = 38;
    test_output_hold_off();
    test_random_batches(200);

    // Full rate on both sides.
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    test_random_batches(200);

    wait_for_results();
    // Any stray result would show up during these cycles.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_hashes.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(TIMEOUT_NS);
    $display("FAIL");
    $finish;
  end

endmodule
